@@ design/rstrs_pkg.sv @@
// Shared types, codes and constants for the rotor self-test ramp sequencer.
package rstrs_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int TIME_W    = 32;
  localparam int CMD_OUT_W = 16;
  localparam int PHASE_W   = 4;
  localparam int DUR_W     = 16;
  localparam int FLOOR_W   = 7;
  localparam int RATE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MS_PER_SEC = 1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_RATE  = 3'd4;

  localparam logic [DUR_W-1:0]   DURATION_RST   = 16'd5000;
  localparam logic [FLOOR_W-1:0] FLOOR_RST      = 7'd20;
  localparam logic [RATE_W-1:0]  UPPER_RATE_RST = 8'd10;
  localparam logic [RATE_W-1:0]  LOWER_RATE_RST = 8'd10;
  localparam logic [RATE_W-1:0]  TAIL_RATE_RST  = 8'd20;

  // test phases
  localparam logic [PHASE_W-1:0] PH_SPINUP     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_UPPER_RISE = 4'd1;
  localparam logic [PHASE_W-1:0] PH_UPPER_FALL = 4'd2;
  localparam logic [PHASE_W-1:0] PH_LOWER_RISE = 4'd3;
  localparam logic [PHASE_W-1:0] PH_LOWER_FALL = 4'd4;
  localparam logic [PHASE_W-1:0] PH_TAIL_RISE  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_TAIL_FALL  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RETURN     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_DONE       = 4'd8;

  typedef enum logic [1:0] {
    ROT_UPPER,
    ROT_LOWER,
    ROT_TAIL
  } rotor_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV_LOAD,
    CS_DIV_RUN,
    CS_APPLY,
    CS_OUT
  } ctl_state_t;

  typedef struct packed {
    logic   accept;
    logic   mul;
    logic   div_load;
    logic   div_step;
    logic   apply;
    logic   load_out;
    rotor_t rotor;
  } ctl_cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
  } ctl_sts_t;

endpackage

@@ design/rstrs_ctrl.sv @@
// Sequencing state machine: multiply, serial divide and update steps per tick.
module rstrs_ctrl #(
  parameter int FRACTION_BITS = rstrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rstrs_pkg::ctl_sts_t sts,
  output rstrs_pkg::ctl_cmd_t cmd
);

  localparam int Q_W = FRACTION_BITS + 9;
  localparam int CNT_W = $clog2(Q_W);

  rstrs_pkg::ctl_state_t state, state_next;
  rstrs_pkg::rotor_t     rotor, rotor_next, first_rotor;
  logic [CNT_W-1:0]      cnt;
  logic                  out_free;
  logic                  active;
  logic                  more_rotors;

  assign out_free    = !out_valid || !out_stall;
  assign active      = sts.phase <= rstrs_pkg::PH_RETURN;
  assign more_rotors = (sts.phase == rstrs_pkg::PH_RETURN) && (rotor != rstrs_pkg::ROT_TAIL);

  always_comb begin
    unique case (sts.phase)
      rstrs_pkg::PH_LOWER_RISE, rstrs_pkg::PH_LOWER_FALL: first_rotor = rstrs_pkg::ROT_LOWER;
      rstrs_pkg::PH_TAIL_RISE, rstrs_pkg::PH_TAIL_FALL:   first_rotor = rstrs_pkg::ROT_TAIL;
      default:                                            first_rotor = rstrs_pkg::ROT_UPPER;
    endcase
  end

  always_comb begin
    unique case (rotor)
      rstrs_pkg::ROT_UPPER: rotor_next = rstrs_pkg::ROT_LOWER;
      default:              rotor_next = rstrs_pkg::ROT_TAIL;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rstrs_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_next = active ? rstrs_pkg::CS_MUL : rstrs_pkg::CS_OUT;
        end
      end
      rstrs_pkg::CS_MUL:      state_next = rstrs_pkg::CS_DIV_LOAD;
      rstrs_pkg::CS_DIV_LOAD: state_next = rstrs_pkg::CS_DIV_RUN;
      rstrs_pkg::CS_DIV_RUN: begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          state_next = rstrs_pkg::CS_APPLY;
        end
      end
      rstrs_pkg::CS_APPLY: begin
        state_next = more_rotors ? rstrs_pkg::CS_MUL : rstrs_pkg::CS_OUT;
      end
      rstrs_pkg::CS_OUT: begin
        if (out_free) begin
          state_next = rstrs_pkg::CS_IDLE;
        end
      end
      default: state_next = rstrs_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == rstrs_pkg::CS_IDLE) && in_valid;
    cmd.mul      = (state == rstrs_pkg::CS_MUL);
    cmd.div_load = (state == rstrs_pkg::CS_DIV_LOAD);
    cmd.div_step = (state == rstrs_pkg::CS_DIV_RUN);
    cmd.apply    = (state == rstrs_pkg::CS_APPLY);
    cmd.load_out = (state == rstrs_pkg::CS_OUT) && out_free;
    cmd.rotor    = rotor;
    in_stall     = (state != rstrs_pkg::CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rstrs_pkg::CS_IDLE;
      rotor     <= rstrs_pkg::ROT_UPPER;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        rotor <= first_rotor;
      end else if (cmd.apply && more_rotors) begin
        rotor <= rotor_next;
      end
      if (cmd.div_load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/rstrs_datapath.sv @@
// Datapath: configuration, tick timing, multiplier, serial divider, ramp update.
module rstrs_datapath #(
  parameter int FRACTION_BITS = rstrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rstrs_pkg::ctl_cmd_t                    cmd,
  output rstrs_pkg::ctl_sts_t                    sts,
  input  logic [rstrs_pkg::TIME_W-1:0]           time_ms,
  input  logic                                   cfg_we,
  input  logic [rstrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rstrs_pkg::CFG_W-1:0]            cfg_data,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] upper_cmd,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] lower_cmd,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] tail_cmd,
  output logic [rstrs_pkg::PHASE_W-1:0]          test_phase
);

  localparam int TW     = rstrs_pkg::TIME_W;
  localparam int CMD_W  = FRACTION_BITS + 8;
  localparam int Q_W    = FRACTION_BITS + 9;
  localparam int SUM_W  = FRACTION_BITS + 11;
  localparam int MULB_W = FRACTION_BITS + 7;
  localparam int PROD_W = TW + MULB_W;
  localparam int DV_W   = TW + rstrs_pkg::RATE_W + FRACTION_BITS;
  localparam int HI_W   = DV_W - Q_W;
  localparam int DW     = rstrs_pkg::DUR_W;
  localparam int EXT_W  = 32;
  localparam logic signed [SUM_W-1:0] FULL_S = SUM_W'(100 * (2 ** FRACTION_BITS));

  // configuration
  logic [rstrs_pkg::DUR_W-1:0]   duration;
  logic [rstrs_pkg::FLOOR_W-1:0] floor_pct;
  logic [rstrs_pkg::RATE_W-1:0]  upper_rate, lower_rate, tail_rate;

  // test state
  logic [rstrs_pkg::PHASE_W-1:0] phase, phase_next;
  logic [TW-1:0]                 start_time, previous_time, dt, el;
  logic signed [CMD_W-1:0]       upper_last, lower_last, tail_last;
  logic signed [CMD_W-1:0]       upper_next, lower_next, tail_next;

  // arithmetic
  logic [DV_W-1:0]   prod;
  logic [DW-1:0]     divisor;
  logic [DW-1:0]     rem;
  logic [Q_W-1:0]    sh;
  logic              ovf;

  logic [rstrs_pkg::FLOOR_W-1:0] floor_eff;
  logic [MULB_W-1:0]             flr;
  logic [DW-1:0]                 dur_eff;
  logic [rstrs_pkg::RATE_W-1:0]  rate_sel;
  logic [TW-1:0]                 mul_a;
  logic [MULB_W-1:0]             mul_b;
  logic [PROD_W-1:0]             mul_p;
  logic                          spinup;
  logic [HI_W-1:0]               hi;
  logic [DW:0]                   rem2;
  logic                          ge;
  logic [Q_W-1:0]                quo;
  logic signed [SUM_W-1:0]       d_ext, last_ext, rise, fall, flr_s, c0;
  logic signed [CMD_W-1:0]       last_sel;
  logic signed [EXT_W-1:0]       up_w, lo_w, tl_w;

  assign sts.phase = phase;
  assign spinup    = (phase == rstrs_pkg::PH_SPINUP);
  assign floor_eff = (floor_pct > rstrs_pkg::FLOOR_W'(100)) ? rstrs_pkg::FLOOR_W'(100) : floor_pct;
  assign flr       = {floor_eff, {FRACTION_BITS{1'b0}}};
  assign dur_eff   = (duration == '0) ? DW'(1) : duration;
  assign flr_s     = SUM_W'(flr);

  always_comb begin
    unique case (cmd.rotor)
      rstrs_pkg::ROT_UPPER: begin
        rate_sel = upper_rate;
        last_sel = upper_last;
      end
      rstrs_pkg::ROT_LOWER: begin
        rate_sel = lower_rate;
        last_sel = lower_last;
      end
      default: begin
        rate_sel = tail_rate;
        last_sel = tail_last;
      end
    endcase
  end

  // spin-up: elapsed * floor / duration; ramps: dt * rate * 2^F / 1000
  assign mul_a = spinup ? el : dt;
  assign mul_b = spinup ? flr : MULB_W'(rate_sel);
  assign mul_p = mul_a * mul_b;

  // restoring division; a quotient that needs more than Q_W bits saturates
  assign hi   = prod[DV_W-1:Q_W];
  assign rem2 = {rem, sh[Q_W-1]};
  assign ge   = rem2 >= {1'b0, divisor};
  assign quo  = ovf ? {Q_W{1'b1}} : sh;

  assign d_ext    = SUM_W'(quo);
  assign last_ext = SUM_W'(last_sel);
  assign rise     = last_ext + d_ext;
  assign fall     = last_ext - d_ext;
  assign c0       = (d_ext > FULL_S) ? FULL_S : d_ext;

  always_comb begin
    upper_next = upper_last;
    lower_next = lower_last;
    tail_next  = tail_last;
    phase_next = phase;
    unique case (phase)
      rstrs_pkg::PH_SPINUP: begin
        upper_next = CMD_W'(c0);
        lower_next = CMD_W'(c0);
        if (el >= TW'(dur_eff)) phase_next = rstrs_pkg::PH_UPPER_RISE;
      end
      rstrs_pkg::PH_UPPER_RISE: begin
        upper_next = CMD_W'(rise);
        if (rise >= FULL_S) begin
          upper_next = CMD_W'(FULL_S);
          phase_next = rstrs_pkg::PH_UPPER_FALL;
        end
      end
      rstrs_pkg::PH_UPPER_FALL: begin
        upper_next = CMD_W'(fall);
        if (fall <= flr_s) begin
          upper_next = CMD_W'(flr_s);
          phase_next = rstrs_pkg::PH_LOWER_RISE;
        end
      end
      rstrs_pkg::PH_LOWER_RISE: begin
        lower_next = CMD_W'(rise);
        if (rise >= FULL_S) begin
          lower_next = CMD_W'(FULL_S);
          phase_next = rstrs_pkg::PH_LOWER_FALL;
        end
      end
      rstrs_pkg::PH_LOWER_FALL: begin
        lower_next = CMD_W'(fall);
        if (fall <= flr_s) begin
          lower_next = CMD_W'(flr_s);
          phase_next = rstrs_pkg::PH_TAIL_RISE;
        end
      end
      rstrs_pkg::PH_TAIL_RISE: begin
        tail_next = CMD_W'(rise);
        if (rise >= FULL_S) begin
          tail_next  = CMD_W'(FULL_S);
          phase_next = rstrs_pkg::PH_TAIL_FALL;
        end
      end
      rstrs_pkg::PH_TAIL_FALL: begin
        tail_next = CMD_W'(fall);
        if (fall <= -FULL_S) begin
          tail_next  = CMD_W'(-FULL_S);
          phase_next = rstrs_pkg::PH_RETURN;
        end
      end
      rstrs_pkg::PH_RETURN: begin
        // tail is updated last, so the done check sees the other two settled
        unique case (cmd.rotor)
          rstrs_pkg::ROT_UPPER: upper_next = (fall <= 0) ? '0 : CMD_W'(fall);
          rstrs_pkg::ROT_LOWER: lower_next = (fall <= 0) ? '0 : CMD_W'(fall);
          default: begin
            tail_next = (rise >= 0) ? '0 : CMD_W'(rise);
            if (upper_last == '0 && lower_last == '0 && rise >= 0) begin
              phase_next = rstrs_pkg::PH_DONE;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= rstrs_pkg::DURATION_RST;
      floor_pct  <= rstrs_pkg::FLOOR_RST;
      upper_rate <= rstrs_pkg::UPPER_RATE_RST;
      lower_rate <= rstrs_pkg::LOWER_RATE_RST;
      tail_rate  <= rstrs_pkg::TAIL_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rstrs_pkg::CFG_DURATION:   duration   <= cfg_data[rstrs_pkg::DUR_W-1:0];
        rstrs_pkg::CFG_FLOOR:      floor_pct  <= cfg_data[rstrs_pkg::FLOOR_W-1:0];
        rstrs_pkg::CFG_UPPER_RATE: upper_rate <= cfg_data[rstrs_pkg::RATE_W-1:0];
        rstrs_pkg::CFG_LOWER_RATE: lower_rate <= cfg_data[rstrs_pkg::RATE_W-1:0];
        rstrs_pkg::CFG_TAIL_RATE:  tail_rate  <= cfg_data[rstrs_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rstrs_pkg::PH_SPINUP;
      start_time    <= '0;
      previous_time <= '0;
      upper_last    <= '0;
      lower_last    <= '0;
      tail_last     <= '0;
    end else begin
      if (cmd.accept) begin
        previous_time <= time_ms;
        if (previous_time == '0) begin
          start_time <= time_ms;
        end
      end
      if (cmd.apply) begin
        phase      <= phase_next;
        upper_last <= upper_next;
        lower_last <= lower_next;
        tail_last  <= tail_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (previous_time == '0) begin
        dt <= '0;
        el <= '0;
      end else begin
        dt <= time_ms - previous_time;
        el <= time_ms - start_time;
      end
    end
    if (cmd.mul) begin
      if (spinup) begin
        prod    <= DV_W'(mul_p);
        divisor <= dur_eff;
      end else begin
        prod    <= DV_W'(mul_p) << FRACTION_BITS;
        divisor <= DW'(rstrs_pkg::MS_PER_SEC);
      end
    end
    if (cmd.div_load) begin
      ovf <= hi >= HI_W'(divisor);
      rem <= hi[DW-1:0];
      sh  <= prod[Q_W-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? DW'(rem2 - {1'b0, divisor}) : rem2[DW-1:0];
      sh  <= {sh[Q_W-2:0], ge};
    end
  end

  assign up_w = EXT_W'(upper_last);
  assign lo_w = EXT_W'(lower_last);
  assign tl_w = EXT_W'(tail_last);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      upper_cmd  <= up_w[rstrs_pkg::CMD_OUT_W-1:0];
      lower_cmd  <= lo_w[rstrs_pkg::CMD_OUT_W-1:0];
      tail_cmd   <= tl_w[rstrs_pkg::CMD_OUT_W-1:0];
      test_phase <= phase;
    end
  end

endmodule

@@ design/rotor_self_test_ramp_sequencer_unit.sv @@
// Top level of the rotor self-test ramp sequencer.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------------
//   input     | in_valid / in_stall  | time_ms
//   output    | out_valid / out_stall| upper_cmd, lower_cmd, tail_cmd, test_phase
//   config    | cfg_we               | cfg_index, cfg_data
//
// One tick at a time. Each rotor update runs a multiply step, a divider load
// step, a restoring divide of FRACTION_BITS+9 quotient bits and an update
// step; the return phase updates all three rotors in turn, and a finished test
// goes straight to the output. Reset is synchronous and loads the register
// defaults. A new tick is taken while a result waits in the output register;
// a stalled output holds the sequencer before its next result.
module rotor_self_test_ramp_sequencer_unit #(
  parameter int FRACTION_BITS = rstrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [rstrs_pkg::TIME_W-1:0]           time_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] upper_cmd,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] lower_cmd,
  output logic signed [rstrs_pkg::CMD_OUT_W-1:0] tail_cmd,
  output logic [rstrs_pkg::PHASE_W-1:0]          test_phase,
  input  logic                                   cfg_we,
  input  logic [rstrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rstrs_pkg::CFG_W-1:0]            cfg_data
);

  rstrs_pkg::ctl_cmd_t cmd;
  rstrs_pkg::ctl_sts_t sts;

  rstrs_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rstrs_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .time_ms   (time_ms),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upper_cmd (upper_cmd),
    .lower_cmd (lower_cmd),
    .tail_cmd  (tail_cmd),
    .test_phase(test_phase)
  );

endmodule
